/* hdl/rtt_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the timer table.
`default_nettype none
package rtt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TIME_W = 48;
  localparam int IV_W   = 32;
  localparam int ID_W   = 16;
  localparam int CNT_W  = 17;
  localparam int DIV_W  = $clog2(TIME_W);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // request modes
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_SCHED   = 2'd1;
  localparam logic [1:0] MODE_CANCEL  = 2'd2;
  localparam logic [1:0] MODE_CLR_ALL = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_FIRE   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_SCHED  = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  typedef struct packed {
    logic load;
    logic sched;
    logic clr_all;
    logic adv;
    logic emit_done;
    logic idx_clr;
    logic idx_inc;
    logic cancel_chk;
    logic emit_cancel;
    logic fire;
    logic div_step;
    logic div_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic quiet;
    logic hit;
    logic need_div;
    logic div_last;
    logic idx_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* hdl/rtt_datapath.sv */
// Datapath of the timer table: slot store, time, remainder unit and result register.
`default_nettype none
module rtt_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire rtt_pkg::dp_cmd_t           cmd,
  output rtt_pkg::dp_sts_t                sts,
  input  wire logic                       wr_en,
  input  wire logic                       wr_data,
  input  wire logic [31:0]                elapsed,
  input  wire logic [31:0]                first_delay,
  input  wire logic [31:0]                repeat_interval,
  input  wire logic signed [16:0]         repeat_count,
  input  wire logic [15:0]                timer_id,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      kind,
  output logic [15:0]                     event_id,
  output logic                            ok,
  output logic                            last
);

  logic                          paused;
  logic [rtt_pkg::TIME_W-1:0]    now;
  logic [rtt_pkg::ID_W-1:0]      next_id;
  logic [rtt_pkg::SLOTS-1:0]     live;
  logic [rtt_pkg::ID_W-1:0]      slot_id   [rtt_pkg::SLOTS];
  logic [rtt_pkg::TIME_W-1:0]    slot_due  [rtt_pkg::SLOTS];
  logic [rtt_pkg::IV_W-1:0]      slot_iv   [rtt_pkg::SLOTS];
  logic signed [rtt_pkg::CNT_W-1:0] slot_left [rtt_pkg::SLOTS];
  logic [rtt_pkg::SLOT_W-1:0]    idx;
  logic [rtt_pkg::ID_W-1:0]      cid;
  logic                          found;
  logic [rtt_pkg::TIME_W-1:0]    dividend;
  logic [rtt_pkg::IV_W-1:0]      rem;
  logic [rtt_pkg::DIV_W-1:0]     dcnt;

  logic [rtt_pkg::TIME_W:0]      adv_sum;
  logic [rtt_pkg::TIME_W-1:0]    now_next;
  logic [rtt_pkg::TIME_W:0]      sch_sum;
  logic [rtt_pkg::SLOT_W-1:0]    free_idx;
  logic                          any_free;
  logic [rtt_pkg::ID_W-1:0]      id_inc;
  logic [rtt_pkg::ID_W-1:0]      cur_id;
  logic [rtt_pkg::TIME_W-1:0]    cur_due;
  logic [rtt_pkg::IV_W-1:0]      cur_iv;
  logic signed [rtt_pkg::CNT_W-1:0] cur_left;
  logic signed [rtt_pkg::CNT_W-1:0] left_next;
  logic                          finish;
  logic [rtt_pkg::TIME_W:0]      step_sum;
  logic                          no_skip;
  logic [rtt_pkg::IV_W:0]        trial;
  logic [rtt_pkg::IV_W:0]        trial_sub;
  logic [rtt_pkg::TIME_W:0]      skip_sum;
  logic                          out_free;

  // time advance and schedule arithmetic
  assign adv_sum  = {1'b0, now} + {{(rtt_pkg::TIME_W-31){1'b0}}, elapsed};
  assign now_next = adv_sum[rtt_pkg::TIME_W] ? rtt_pkg::TIME_MAX : adv_sum[rtt_pkg::TIME_W-1:0];
  assign sch_sum  = {1'b0, now} + {{(rtt_pkg::TIME_W-31){1'b0}}, first_delay};
  assign id_inc   = next_id + rtt_pkg::ID_W'(1);

  // find lowest free slot
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = rtt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_idx = rtt_pkg::SLOT_W'(i);
        any_free = 1'b1;
      end
    end
  end

  // entry under scan and its rescheduling
  assign cur_id    = slot_id[idx];
  assign cur_due   = slot_due[idx];
  assign cur_iv    = slot_iv[idx];
  assign cur_left  = slot_left[idx];
  assign left_next = (cur_left > 0) ? cur_left - rtt_pkg::CNT_W'(1) : cur_left;
  assign finish    = (left_next == '0);
  assign step_sum  = {1'b0, cur_due} + {{(rtt_pkg::TIME_W-31){1'b0}}, cur_iv};
  assign no_skip   = (step_sum >= {1'b0, now});

  // remainder step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem, dividend[rtt_pkg::TIME_W-1]};
  assign trial_sub = trial - {1'b0, cur_iv};
  assign skip_sum  = {1'b0, now} + {{(rtt_pkg::TIME_W-rtt_pkg::IV_W+1){1'b0}}, cur_iv - rem};

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts.quiet    = paused || (elapsed == '0);
    sts.hit      = live[idx] && (cur_due <= now);
    sts.need_div = !finish && (cur_iv != '0) && !no_skip;
    sts.div_last = (dcnt == rtt_pkg::DIV_W'(rtt_pkg::TIME_W - 1));
    sts.idx_last = (idx == rtt_pkg::SLOT_W'(rtt_pkg::SLOTS - 1));
    sts.out_free = out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      paused  <= 1'b0;
      now     <= '0;
      next_id <= rtt_pkg::ID_W'(1);
      live    <= '0;
      idx     <= '0;
      found   <= 1'b0;
      dcnt    <= '0;
    end else begin
      if (wr_en) paused <= wr_data;
      if (cmd.adv) now <= now_next;
      if (cmd.sched && any_free) begin
        live[free_idx] <= 1'b1;
        next_id        <= (id_inc == '0) ? rtt_pkg::ID_W'(1) : id_inc;
      end
      if (cmd.clr_all) live <= '0;
      if (cmd.idx_clr) begin
        idx   <= '0;
        found <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx <= idx + rtt_pkg::SLOT_W'(1);
      end
      if (cmd.cancel_chk && live[idx] && (cur_id == cid)) begin
        live[idx] <= 1'b0;
        found     <= 1'b1;
      end
      if (cmd.fire && finish) live[idx] <= 1'b0;
      if (cmd.fire) dcnt <= '0;
      else if (cmd.div_step) dcnt <= dcnt + rtt_pkg::DIV_W'(1);
    end
  end

  // slot payload, latched id and remainder unit
  always_ff @(posedge clk) begin
    if (cmd.load) cid <= timer_id;
    if (cmd.sched && any_free) begin
      slot_id[free_idx]   <= next_id;
      slot_due[free_idx]  <= sch_sum[rtt_pkg::TIME_W] ? rtt_pkg::TIME_MAX
                                                      : sch_sum[rtt_pkg::TIME_W-1:0];
      slot_iv[free_idx]   <= repeat_interval;
      slot_left[free_idx] <= repeat_count;
    end
    if (cmd.fire) begin
      slot_left[idx] <= left_next;
      if (cur_iv == '0) begin
        slot_due[idx] <= now;
      end else if (no_skip) begin
        slot_due[idx] <= step_sum[rtt_pkg::TIME_W] ? rtt_pkg::TIME_MAX
                                                   : step_sum[rtt_pkg::TIME_W-1:0];
      end
      dividend <= now - step_sum[rtt_pkg::TIME_W-1:0];
      rem      <= '0;
    end
    if (cmd.div_step) begin
      dividend <= {dividend[rtt_pkg::TIME_W-2:0], 1'b0};
      rem      <= trial_sub[rtt_pkg::IV_W] ? trial[rtt_pkg::IV_W-1:0]
                                           : trial_sub[rtt_pkg::IV_W-1:0];
    end
    if (cmd.div_wr) begin
      slot_due[idx] <= skip_sum[rtt_pkg::TIME_W] ? rtt_pkg::TIME_MAX
                                                 : skip_sum[rtt_pkg::TIME_W-1:0];
    end
  end

  // result register: valid is control, fields are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_done || cmd.sched || cmd.clr_all || cmd.emit_cancel || cmd.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      kind     <= rtt_pkg::KIND_FIRE;
      event_id <= cur_id;
      ok       <= 1'b0;
      last     <= 1'b0;
    end else if (cmd.emit_done) begin
      kind     <= rtt_pkg::KIND_DONE;
      event_id <= '0;
      ok       <= 1'b0;
      last     <= 1'b1;
    end else if (cmd.sched) begin
      kind     <= rtt_pkg::KIND_SCHED;
      event_id <= any_free ? next_id : '0;
      ok       <= any_free;
      last     <= 1'b1;
    end else if (cmd.clr_all) begin
      kind     <= rtt_pkg::KIND_CANCEL;
      event_id <= '0;
      ok       <= |live;
      last     <= 1'b1;
    end else if (cmd.emit_cancel) begin
      kind     <= rtt_pkg::KIND_CANCEL;
      event_id <= cid;
      ok       <= found;
      last     <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/rtt_ctrl.sv */
// Controller of the timer table: sequences ticks, cancels and skip-ahead remainders.
`default_nettype none
module rtt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       mode,
  input  wire rtt_pkg::dp_sts_t sts,
  output rtt_pkg::dp_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_DWR    = 7'b0001000,
    S_TDONE  = 7'b0010000,
    S_CANCEL = 7'b0100000,
    S_CFIN   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) && sts.out_free);
  assign accept   = in_valid && !in_stall;

  // decode state into datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (mode)
            rtt_pkg::MODE_TICK: begin
              if (sts.quiet) begin
                cmd.emit_done = 1'b1;
              end else begin
                cmd.adv     = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = S_SCAN;
              end
            end
            rtt_pkg::MODE_SCHED:  cmd.sched = 1'b1;
            rtt_pkg::MODE_CANCEL: begin
              cmd.idx_clr = 1'b1;
              state_next  = S_CANCEL;
            end
            default: cmd.clr_all = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (!sts.hit || sts.out_free) begin
          cmd.fire = sts.hit;
          if (sts.hit && sts.need_div) begin
            state_next = S_DIV;
          end else if (sts.idx_last) begin
            state_next = S_TDONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DWR;
      end
      S_DWR: begin
        cmd.div_wr = 1'b1;
        if (sts.idx_last) begin
          state_next = S_TDONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_TDONE: begin
        if (sts.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CANCEL: begin
        cmd.cancel_chk = 1'b1;
        cmd.idx_inc    = 1'b1;
        if (sts.idx_last) state_next = S_CFIN;
      end
      S_CFIN: begin
        if (sts.out_free) begin
          cmd.emit_cancel = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/repeating_timer_table_top.sv */
// Top level of the repeating timer table.
//
//  channel   valid      stall      payload
//  request   in_valid   in_stall   mode, elapsed, first_delay, repeat_interval,
//                                  repeat_count, timer_id
//  result    out_valid  out_stall  kind, event_id, ok, last
//  config    wr_en      -          wr_data (paused)
//
// Schedule, cancel all and a paused or zero tick are answered in the cycle after they are accepted.
// Cancel one walks the slot store, checking every slot in turn, then answers.
// A tick walks the slots in turn; every timer that must skip ahead also runs the
// 48-step remainder unit and its write-back, and the walk ends with the done marker.
// One request at a time; a stalled result holds the walk at the next fire.
// Synchronous reset clears time, ids, live bits, pause and control state.
`default_nettype none
module repeating_timer_table_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic [31:0]        elapsed,
  input  wire logic [31:0]        first_delay,
  input  wire logic [31:0]        repeat_interval,
  input  wire logic signed [16:0] repeat_count,
  input  wire logic [15:0]        timer_id,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              kind,
  output logic [15:0]             event_id,
  output logic                    ok,
  output logic                    last,
  input  wire logic               wr_en,
  input  wire logic               wr_data
);

  rtt_pkg::dp_cmd_t cmd;
  rtt_pkg::dp_sts_t sts;

  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtt_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .wr_en           (wr_en),
    .wr_data         (wr_data),
    .elapsed         (elapsed),
    .first_delay     (first_delay),
    .repeat_interval (repeat_interval),
    .repeat_count    (repeat_count),
    .timer_id        (timer_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .event_id        (event_id),
    .ok              (ok),
    .last            (last)
  );

endmodule
`default_nettype wire

/* hdl/rtt_checker.sv */
// Port-level checks on the timer table and their binding to the top level.
`default_nettype none
module rtt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  mode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  kind,
  input wire logic [15:0] event_id,
  input wire logic        ok,
  input wire logic        last
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(event_id) && $stable(last))
    else $error("stalled result changed");

  // answer a schedule request on the next cycle
  a_sched: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == rtt_pkg::MODE_SCHED)
      |=> out_valid && (kind == rtt_pkg::KIND_SCHED) && last)
    else $error("schedule reply missing");

  // fire events never close a request, every other kind does
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind != rtt_pkg::KIND_FIRE)))
    else $error("last flag wrong for kind");

  // a successful schedule never hands out id zero
  a_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == rtt_pkg::KIND_SCHED) && ok |-> (event_id != 16'd0))
    else $error("zero id given out");

endmodule

bind repeating_timer_table_top rtt_checker u_rtt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .mode      (mode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .event_id  (event_id),
  .ok        (ok),
  .last      (last)
);
`default_nettype wire
